@@ hw/rtl/ptb_pkg.sv @@
// Package for the plane tangent basis block: widths, lane names and the result word type.
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

    // default fraction bits of the vector components
    localparam int FRAC_BITS_DEF = 15;

    // component and lane shape
    localparam int COMP_W = 16;
    localparam int LANES  = 6;

    // intermediate widths
    localparam int SQ_W   = 31;   // square of a 16-bit signed component
    localparam int PROD_W = 32;   // signed product of two components
    localparam int MAG_W  = 31;   // magnitude of such a product
    localparam int PSQ_W  = 62;   // square of that magnitude
    localparam int DEN_W  = 32;   // sum of two squares
    localparam int ROOT_BITS = 17; // bits of the odd root search
    localparam int REM_W  = 65;   // remainder, saturated numerator
    localparam int MD_W   = 49;   // root times denominator
    localparam int TRY_W  = 67;   // trial subtrahend
    localparam int Q_W    = 17;   // rounded magnitude before capping

    localparam logic [Q_W-1:0] POS_CAP = 17'd32767;
    localparam logic [Q_W-1:0] NEG_CAP = 17'd32768;

    // lane positions inside the result word
    localparam int LANE_T0X = 0;
    localparam int LANE_T0Y = 1;
    localparam int LANE_T0Z = 2;
    localparam int LANE_T1X = 3;
    localparam int LANE_T1Y = 4;
    localparam int LANE_T1Z = 5;

    typedef logic signed [COMP_W-1:0] t_comp;

    // one result: six tangent components and the degenerate flag
    typedef struct packed {
        logic                 deg;
        t_comp [LANES-1:0]    tan;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/plane_tangent_basis.sv @@
// Plane tangent basis: two saturated Q1.15 tangents from a unit normal, fully pipelined.
//
//  channel   dir  bits  contents (lowest bit first)
//  s_axis    in   48    tdata: normal_x, normal_y, normal_z
//  m_axis    out  96+1  tdata: tan0_x, tan0_y, tan0_z, tan1_x, tan1_y, tan1_z
//                       tuser: degenerate
//
//  One word enters per clock while s_axis_tready is high. 22 register stages: three stages for
//  squares, products and lane set-up, seventeen for the bit-per-stage odd-root search (one
//  stage per root bit, six lanes side by side), one for rounding and capping, one output
//  register. i_rst_n is synchronous and clears valid bits only.
//  A skid register behind the output register takes a word while the output waits;
//  s_axis_tready drops only when the skid register is full, and the pipeline then holds.
`timescale 1ns / 1ps
`default_nettype none

module plane_tangent_basis #(
    parameter int FRAC_BITS = ptb_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // normal_x, normal_y, normal_z
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // tan0_x, tan0_y, tan0_z, tan1_x, tan1_y, tan1_z
    output logic             m_axis_tuser    // degenerate
);

    localparam int SQ_W      = ptb_pkg::SQ_W;
    localparam int PROD_W    = ptb_pkg::PROD_W;
    localparam int MAG_W     = ptb_pkg::MAG_W;
    localparam int PSQ_W     = ptb_pkg::PSQ_W;
    localparam int DEN_W     = ptb_pkg::DEN_W;
    localparam int ROOT_BITS = ptb_pkg::ROOT_BITS;
    localparam int REM_W     = ptb_pkg::REM_W;
    localparam int MD_W      = ptb_pkg::MD_W;
    localparam int TRY_W     = ptb_pkg::TRY_W;
    localparam int Q_W       = ptb_pkg::Q_W;
    localparam int LANES     = ptb_pkg::LANES;
    localparam int COMP_W    = ptb_pkg::COMP_W;

    // 4 * v * 2^(2F) before saturation to the remainder width
    localparam int SH_RAW = SQ_W + 2 + 2 * FRAC_BITS;
    localparam int SH_W   = (SH_RAW > REM_W) ? SH_RAW : REM_W + 1;
    // threshold 2^(2F) for the z branch test
    localparam int CMP_W  = (2 * FRAC_BITS + 1 > SQ_W + 1) ? 2 * FRAC_BITS + 1 : SQ_W + 1;
    localparam logic [CMP_W-1:0] ONE2 = {{(CMP_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);

    // saturated 4 * v * S^2
    function automatic logic [REM_W-1:0] f_scaled(input logic [SQ_W-1:0] v);
        logic [SH_W-1:0] w;
        w = SH_W'(v) << (2 * FRAC_BITS + 2);
        if (w[SH_W-1:REM_W] != '0) begin
            f_scaled = '1;
        end else begin
            f_scaled = w[REM_W-1:0];
        end
    endfunction

    // magnitude of a signed product
    function automatic logic [MAG_W-1:0] f_mag(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] a;
        a = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
        f_mag = a[MAG_W-1:0];
    endfunction

    logic ce;
    logic r_skid_v;

    assign ce            = !r_skid_v;
    assign s_axis_tready = ce;

    // ---------------------------------------------------------------- stage 1
    // squares and cross products of the components
    logic                     r1_v;
    logic [SQ_W-1:0]          r1_x2, r1_y2, r1_z2;
    logic signed [PROD_W-1:0] r1_pxy, r1_pxz, r1_pyz;
    logic                     r1_sx, r1_sy, r1_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (ce) begin
            r1_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [COMP_W-1:0] x, y, z;
        logic signed [PROD_W-1:0] x2, y2, z2;
        x  = $signed(s_axis_tdata[15:0]);
        y  = $signed(s_axis_tdata[31:16]);
        z  = $signed(s_axis_tdata[47:32]);
        x2 = x * x;
        y2 = y * y;
        z2 = z * z;
        if (ce) begin
            r1_x2  <= x2[SQ_W-1:0];
            r1_y2  <= y2[SQ_W-1:0];
            r1_z2  <= z2[SQ_W-1:0];
            r1_pxy <= x * y;
            r1_pxz <= x * z;
            r1_pyz <= y * z;
            r1_sx  <= x[COMP_W-1];
            r1_sy  <= y[COMP_W-1];
            r1_sz  <= z[COMP_W-1];
        end
    end

    // ---------------------------------------------------------------- stage 2
    // branch test, sums of squares, squared cross products
    logic             r2_v;
    logic             r2_zb;
    logic [DEN_W-1:0] r2_az, r2_axy;
    logic [SQ_W-1:0]  r2_x2, r2_y2, r2_z2;
    logic [PSQ_W-1:0] r2_qxy, r2_qxz, r2_qyz;
    logic             r2_sx, r2_sy, r2_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (ce) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [MAG_W-1:0] mxy, mxz, myz;
        mxy = f_mag(r1_pxy);
        mxz = f_mag(r1_pxz);
        myz = f_mag(r1_pyz);
        if (ce) begin
            r2_zb  <= CMP_W'({r1_z2, 1'b0}) > ONE2;
            r2_az  <= DEN_W'(r1_y2) + DEN_W'(r1_z2);
            r2_axy <= DEN_W'(r1_x2) + DEN_W'(r1_y2);
            r2_x2  <= r1_x2;
            r2_y2  <= r1_y2;
            r2_z2  <= r1_z2;
            r2_qxy <= PSQ_W'(mxy) * PSQ_W'(mxy);
            r2_qxz <= PSQ_W'(mxz) * PSQ_W'(mxz);
            r2_qyz <= PSQ_W'(myz) * PSQ_W'(myz);
            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;
            r2_sz  <= r1_sz;
        end
    end

    // ---------------------------------------------------------------- root pipeline
    // index 0 is the lane set-up; index i holds the word after i root bits
    logic                                r_v   [0:ROOT_BITS];
    logic                                r_dg  [0:ROOT_BITS];
    logic [LANES-1:0]                    r_neg [0:ROOT_BITS];
    logic [LANES-1:0][REM_W-1:0]         r_rem [0:ROOT_BITS];
    logic [LANES-1:0][DEN_W-1:0]         r_den [0:ROOT_BITS];
    logic [LANES-1:0][ROOT_BITS-1:0]     r_m   [0:ROOT_BITS];
    logic [LANES-1:0][MD_W-1:0]          r_md  [0:ROOT_BITS];

    // stage 3: per-lane numerator, denominator and sign for the chosen branch
    logic                        n_dg;
    logic [LANES-1:0]            n_neg;
    logic [LANES-1:0][REM_W-1:0] n_rem;
    logic [LANES-1:0][DEN_W-1:0] n_den;

    always_comb begin
        n_neg = '0;
        n_rem = '0;
        n_dg  = 1'b0;
        if (r2_zb) begin
            // basis from y and z
            n_den                    = {LANES{r2_az}};
            n_den[ptb_pkg::LANE_T1X] = DEN_W'(1);
            n_rem[ptb_pkg::LANE_T0Y] = f_scaled(r2_z2);
            n_neg[ptb_pkg::LANE_T0Y] = !r2_sz;
            n_rem[ptb_pkg::LANE_T0Z] = f_scaled(r2_y2);
            n_neg[ptb_pkg::LANE_T0Z] = r2_sy;
            n_rem[ptb_pkg::LANE_T1X] = REM_W'(r2_az) << 2;
            n_rem[ptb_pkg::LANE_T1Y] = REM_W'(r2_qxy) << 2;
            n_neg[ptb_pkg::LANE_T1Y] = (r2_sx == r2_sy);
            n_rem[ptb_pkg::LANE_T1Z] = REM_W'(r2_qxz) << 2;
            n_neg[ptb_pkg::LANE_T1Z] = (r2_sx == r2_sz);
        end else begin
            // basis from x and y; x = y = 0 is degenerate
            n_den                    = {LANES{r2_axy}};
            n_den[ptb_pkg::LANE_T1Z] = DEN_W'(1);
            n_rem[ptb_pkg::LANE_T0X] = f_scaled(r2_y2);
            n_neg[ptb_pkg::LANE_T0X] = !r2_sy;
            n_rem[ptb_pkg::LANE_T0Y] = f_scaled(r2_x2);
            n_neg[ptb_pkg::LANE_T0Y] = r2_sx;
            n_rem[ptb_pkg::LANE_T1X] = REM_W'(r2_qxz) << 2;
            n_neg[ptb_pkg::LANE_T1X] = (r2_sx == r2_sz);
            n_rem[ptb_pkg::LANE_T1Y] = REM_W'(r2_qyz) << 2;
            n_neg[ptb_pkg::LANE_T1Y] = (r2_sy == r2_sz);
            n_rem[ptb_pkg::LANE_T1Z] = REM_W'(r2_axy) << 2;
            n_dg                     = (r2_axy == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (ce) begin
            r_v[0] <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dg[0]  <= n_dg;
            r_neg[0] <= n_neg;
            r_rem[0] <= n_rem;
            r_den[0] <= n_den;
            r_m[0]   <= '0;
            r_md[0]  <= '0;
        end
    end

    // one root bit per stage: largest m with m*m*den <= numerator
    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_root
        localparam int K = ROOT_BITS - 1 - g;

        logic [LANES-1:0][REM_W-1:0]     n_rem_s;
        logic [LANES-1:0][ROOT_BITS-1:0] n_m_s;
        logic [LANES-1:0][MD_W-1:0]      n_md_s;

        always_comb begin
            logic [TRY_W-1:0] t;
            for (int l = 0; l < LANES; l++) begin
                // (m + 2^K)^2 den - m^2 den
                t = (TRY_W'(r_md[g][l]) << (K + 1)) + (TRY_W'(r_den[g][l]) << (2 * K));
                if (TRY_W'(r_rem[g][l]) >= t) begin
                    n_rem_s[l] = r_rem[g][l] - t[REM_W-1:0];
                    n_m_s[l]   = r_m[g][l] | (ROOT_BITS'(1) << K);
                    n_md_s[l]  = r_md[g][l] + (MD_W'(r_den[g][l]) << K);
                end else begin
                    n_rem_s[l] = r_rem[g][l];
                    n_m_s[l]   = r_m[g][l];
                    n_md_s[l]  = r_md[g][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (ce) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                r_dg[g+1]  <= r_dg[g];
                r_neg[g+1] <= r_neg[g];
                r_den[g+1] <= r_den[g];
                r_rem[g+1] <= n_rem_s;
                r_m[g+1]   <= n_m_s;
                r_md[g+1]  <= n_md_s;
            end
        end
    end

    // ---------------------------------------------------------------- rounding stage
    // q = (m + 1) / 2, capped by sign, negated, zeroed when degenerate
    logic             r_fv;
    ptb_pkg::t_result r_fin;
    ptb_pkg::t_result n_fin;

    always_comb begin
        logic [Q_W:0]   m1;
        logic [Q_W-1:0] q, cap;
        logic [Q_W-1:0] sv;
        n_fin.deg = r_dg[ROOT_BITS];
        for (int l = 0; l < LANES; l++) begin
            m1  = (Q_W + 1)'(r_m[ROOT_BITS][l]) + (Q_W + 1)'(1);
            q   = m1[Q_W:1];
            cap = r_neg[ROOT_BITS][l] ? ptb_pkg::NEG_CAP : ptb_pkg::POS_CAP;
            if (q > cap) begin
                q = cap;
            end
            sv = r_neg[ROOT_BITS][l] ? Q_W'(-q) : q;
            n_fin.tan[l] = r_dg[ROOT_BITS] ? '0 : sv[COMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (ce) begin
            r_fv <= r_v[ROOT_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_fin <= n_fin;
        end
    end

    // ---------------------------------------------------------------- output and skid
    logic             r_out_v;
    ptb_pkg::t_result r_out;
    ptb_pkg::t_result r_skid;
    logic             out_free;
    logic             incoming;

    assign out_free = !r_out_v || m_axis_tready;
    assign incoming = ce && r_fv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= incoming;
            end
        end else if (incoming) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : r_fin;
        end
        if (!out_free && incoming) begin
            r_skid <= r_fin;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out.tan;
    assign m_axis_tuser  = r_out.deg;

endmodule

`default_nettype wire
